// ===== design/msfe_pkg.sv =====
// Shared types, constants and helpers of the Mode S frame encoder.
// Used by msfe_ctrl, msfe_dp and mode_s_frame_encoder; no dependencies.
`timescale 1ns / 1ps

package msfe_pkg;

  // CRC-24 generator, x^24 term implied
  localparam logic [23:0] CRC_POLY = 24'hFFF409;

  // Chip pair codes: first chip in bit 1
  localparam logic [1:0] PAIR_ONE  = 2'b10;
  localparam logic [1:0] PAIR_ZERO = 2'b01;

  // Result kinds
  localparam logic [1:0] KIND_PRE  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_CRC  = 2'd2;

  localparam int unsigned PRE_PAIRS  = 8;
  localparam int unsigned BYTE_PAIRS = 8;
  localparam int unsigned CRC_PAIRS  = 24;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] chip_pair;
    logic [1:0] pair_kind;
    logic       frame_end;
    logic       last_of_item;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;         // take a new byte
    logic       emit;         // produce one pair into the output register
    logic [1:0] kind;         // which source feeds the pair
    logic [2:0] pre_idx;      // preamble pair position
    logic       frame_end;
    logic       last_of_item;
  } msfe_cmd_t;

  // Preamble 1010000101000000 as chip pairs
  function automatic logic [1:0] preamble_pair(input logic [2:0] idx);
    logic [1:0] pair;
    case (idx)
      3'd0:    pair = 2'b10;
      3'd1:    pair = 2'b10;
      3'd3:    pair = 2'b01;
      3'd4:    pair = 2'b01;
      default: pair = 2'b00;
    endcase
    return pair;
  endfunction

  function automatic logic [1:0] bit_pair(input logic b);
    return b ? PAIR_ONE : PAIR_ZERO;
  endfunction

endpackage

// ===== design/mode_s_frame_encoder.sv =====
// Top level of the Mode S frame encoder: controller plus datapath.
// Depends on msfe_pkg, msfe_ctrl and msfe_dp.
`timescale 1ns / 1ps

// Takes payload bytes of a Mode S frame and gives pulse-position chip pairs,
// one per cycle unless out_ready_i holds the output register, through a
// single registered output stage: 8 preamble pairs before the first byte of
// a frame, 8 pairs per byte (MSB first, 10 for a one, 01 for a zero), and
// after the byte flagged last the 24 CRC-24 parity pairs, the final one
// marked frame_end. The next byte is taken in the cycle of the previous
// byte's final pair, or at the first edge it is offered while the block is
// idle; once it is taken, the registered controller state starts its pairs,
// the preamble first for the first byte of a frame. The CRC runs
// bit-serially alongside the data pairs and is empty again after the
// parity.

module mode_s_frame_encoder
  import msfe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  msfe_cmd_t cmd;

  msfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .last_byte_i (in_item_i.last_byte),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  msfe_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .payload_byte_i (in_item_i.payload_byte),
    .out_item_o     (out_item_o)
  );

endmodule

// ===== design/msfe_dp.sv =====
// Datapath of the Mode S frame encoder: byte shifter, bit-serial CRC-24 and
// output register. Depends on msfe_pkg.
`timescale 1ns / 1ps

module msfe_dp
  import msfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  msfe_cmd_t  cmd_i,
  input  logic [7:0] payload_byte_i,
  output out_item_t  out_item_o
);

  logic [7:0]  byte_q, byte_d;
  logic [23:0] crc_q, crc_d;
  out_item_t   out_q, out_d;
  logic        fb;

  // feedback of one MSB-first CRC step
  assign fb = crc_q[23] ^ byte_q[7];

  always_comb begin
    byte_d = byte_q;
    crc_d  = crc_q;
    out_d  = out_q;
    if (cmd_i.emit) begin
      out_d.pair_kind    = cmd_i.kind;
      out_d.frame_end    = cmd_i.frame_end;
      out_d.last_of_item = cmd_i.last_of_item;
      case (cmd_i.kind)
        KIND_PRE: begin
          out_d.chip_pair = preamble_pair(cmd_i.pre_idx);
        end
        KIND_DATA: begin
          out_d.chip_pair = bit_pair(byte_q[7]);
          byte_d = {byte_q[6:0], 1'b0};
          crc_d  = {crc_q[22:0], 1'b0} ^ (fb ? CRC_POLY : 24'd0);
        end
        KIND_CRC: begin
          // shifting the parity out leaves the remainder cleared
          out_d.chip_pair = bit_pair(crc_q[23]);
          crc_d = {crc_q[22:0], 1'b0};
        end
        default: begin
          out_d.chip_pair = 2'b00;
        end
      endcase
    end
    if (cmd_i.load) begin
      byte_d = payload_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= 24'd0;
    end else begin
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    out_q  <= out_d;
  end

  assign out_item_o = out_q;

endmodule

// ===== design/msfe_ctrl.sv =====
// Controller of the Mode S frame encoder: phase sequencing, pair counting,
// handshakes and output valid. Depends on msfe_pkg.
`timescale 1ns / 1ps

module msfe_ctrl
  import msfe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      last_byte_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output msfe_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PRE  = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;
  localparam logic [1:0] ST_CRC  = 2'd3;

  localparam logic [4:0] PRE_END  = 5'(PRE_PAIRS - 1);
  localparam logic [4:0] BYTE_END = 5'(BYTE_PAIRS - 1);
  localparam logic [4:0] CRC_END  = 5'(CRC_PAIRS - 1);

  logic [1:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       last_q, last_d;
  logic       in_frame_q, in_frame_d;
  logic       out_valid_q, out_valid_d;

  logic advance, emit, final_pair, crc_done, accept, frame_open;

  // a pair moves into the output register when it is free or being taken
  assign advance    = !out_valid_q || out_ready_i;
  assign emit       = (state_q != ST_IDLE) && advance;
  assign crc_done   = (state_q == ST_CRC) && (cnt_q == CRC_END);
  assign final_pair = crc_done || ((state_q == ST_DATA) && (cnt_q == BYTE_END) && !last_q);
  assign in_ready_o = (state_q == ST_IDLE) || (emit && final_pair);
  assign accept     = in_valid_i && in_ready_o;
  assign frame_open = in_frame_q && !crc_done;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    in_frame_d  = frame_open;
    out_valid_d = emit ? 1'b1 : (out_valid_q && !out_ready_i);

    if (emit) begin
      cnt_d = cnt_q + 5'd1;
      case (state_q)
        ST_PRE: begin
          if (cnt_q == PRE_END) begin
            state_d = ST_DATA;
            cnt_d   = 5'd0;
          end
        end
        ST_DATA: begin
          if (cnt_q == BYTE_END) begin
            state_d = last_q ? ST_CRC : ST_IDLE;
            cnt_d   = 5'd0;
          end
        end
        ST_CRC: begin
          if (cnt_q == CRC_END) begin
            state_d = ST_IDLE;
            cnt_d   = 5'd0;
          end
        end
        default: begin
          cnt_d = 5'd0;
        end
      endcase
    end

    if (accept) begin
      state_d    = frame_open ? ST_DATA : ST_PRE;
      cnt_d      = 5'd0;
      last_d     = last_byte_i;
      in_frame_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 5'd0;
      last_q      <= 1'b0;
      in_frame_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      in_frame_q  <= in_frame_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    cmd_o.load         = accept;
    cmd_o.emit         = emit;
    cmd_o.pre_idx      = cnt_q[2:0];
    cmd_o.frame_end    = crc_done;
    cmd_o.last_of_item = final_pair;
    case (state_q)
      ST_PRE:  cmd_o.kind = KIND_PRE;
      ST_DATA: cmd_o.kind = KIND_DATA;
      ST_CRC:  cmd_o.kind = KIND_CRC;
      default: cmd_o.kind = KIND_PRE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  // no item is taken while the preamble is going out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRE) |-> !in_ready_o)
    else $error("item accepted during preamble");

  // counter stays inside its phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_PRE) || (state_q == ST_DATA)) |-> (cnt_q <= BYTE_END))
    else $error("pair counter beyond byte phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CRC) |-> (cnt_q <= CRC_END))
    else $error("pair counter beyond parity phase");

  // the frame end pair also closes its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && crc_done) |=> (out_valid_q && !in_frame_q) || (out_valid_q && state_q != ST_IDLE))
    else $error("frame end without closing state");

  // an accepted item always produces a pending pair next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_PRE) || (state_q == ST_DATA))
    else $error("accepted item not started");

endmodule
